@@ design/stis_pkg.sv @@
// Shared types and constants for the sorted table interval search block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package stis_pkg;

    localparam int ENTRY_INDEX_W = 10;
    localparam int SAMPLE_W      = 32;
    localparam int NUM_POINTS_W  = 11;
    localparam int INTERVAL_W    = 10;

    localparam logic [NUM_POINTS_W-1:0] NUM_POINTS_RESET = 11'd1024;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } stis_state_t;

    typedef struct packed {
        logic load_wr;
        logic init;
        logic step;
        logic out_load;
    } stis_cmd_t;

    typedef struct packed {
        logic span_gt1;
    } stis_status_t;

endpackage

`default_nettype wire

@@ design/stis_req_if.sv @@
// Request channel: load or query transactions with valid/ready handshake.
// Depends on stis_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface stis_req_if
    import stis_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [ENTRY_INDEX_W-1:0]   entry_index;
    logic signed [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output req_type, output entry_index,
                    output sample_value, input ready);
    modport sink   (input valid, input req_type, input entry_index,
                    input sample_value, output ready);
endinterface

`default_nettype wire

@@ design/stis_rsp_if.sv @@
// Response channel: interval index transactions with valid/ready handshake.
// Depends on stis_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface stis_rsp_if
    import stis_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [INTERVAL_W-1:0] interval_index;

    modport source (output valid, output interval_index, input ready);
    modport sink   (input valid, input interval_index, output ready);
endinterface

`default_nettype wire

@@ design/stis_ctrl.sv @@
// Controller state machine: request acceptance, search sequencing, result hand-off.
// Depends on stis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stis_ctrl
    import stis_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    input  wire logic         req_type,
    output logic              req_ready,
    input  wire logic         rsp_ready,
    output logic              rsp_valid,
    input  wire stis_status_t status,
    output stis_cmd_t         cmd
);

    stis_state_t state_reg;
    stis_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        req_fire;
    logic        out_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req_type == REQ_QUERY)
                    begin
                        cmd.init   = 1'b1;
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (status.span_gt1)
                begin
                    cmd.step = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

`default_nettype wire

@@ design/stis_dpath.sv @@
// Datapath: breakpoint memory, bisection bounds, compare and result register.
// Depends on stis_pkg; driven by stis_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module stis_dpath
    import stis_pkg::*;
#(
    parameter int MAX_POINTS  = 1024,
    parameter int VALUE_WIDTH = 32
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire stis_cmd_t                  cmd,
    input  wire logic [ENTRY_INDEX_W-1:0]   entry_index,
    input  wire logic signed [SAMPLE_W-1:0] sample_value,
    input  wire logic                       cfg_wr_en,
    input  wire logic [NUM_POINTS_W-1:0]    cfg_wr_data,
    output stis_status_t                    status,
    output logic [INTERVAL_W-1:0]           interval_index
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CNT_W = (AW + 1 > NUM_POINTS_W) ? AW + 1 : NUM_POINTS_W;

    logic [VALUE_WIDTH-1:0]          mem [MAX_POINTS];
    logic [VALUE_WIDTH-1:0]          rd_data_reg;
    logic [VALUE_WIDTH-1:0]          key_reg;
    logic [VALUE_WIDTH-1:0]          value_in;
    logic [VALUE_WIDTH+SAMPLE_W-1:0] value_ext;
    logic [NUM_POINTS_W-1:0]         num_points_reg;
    logic [AW-1:0]                   left_reg;
    logic [AW-1:0]                   left_next;
    logic [AW-1:0]                   right_reg;
    logic [AW-1:0]                   right_next;
    logic [AW-1:0]                   rd_addr;
    logic [AW-1:0]                   rd_addr_hold;
    logic [AW:0]                     bound_sum;
    logic [AW-1:0]                   span;
    logic [AW+ENTRY_INDEX_W-1:0]     pos_ext;
    logic                            pos_in_range;
    logic [AW+INTERVAL_W-1:0]        left_ext;
    logic [CNT_W-1:0]                count_raw;
    logic [CNT_W-1:0]                count_sat;
    logic [CNT_W-1:0]                count_m1;
    logic                            count_ge2;
    logic                            key_greater;
    logic [INTERVAL_W-1:0]           interval_reg;

    assign value_ext    = {{VALUE_WIDTH{1'b0}}, sample_value};
    assign value_in     = value_ext[VALUE_WIDTH-1:0];
    assign pos_ext      = {{AW{1'b0}}, entry_index};
    assign pos_in_range = (pos_ext < (AW + ENTRY_INDEX_W)'(MAX_POINTS));

    assign count_raw = {{(CNT_W - NUM_POINTS_W){1'b0}}, num_points_reg};
    assign count_sat = (count_raw > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_raw;
    assign count_m1  = count_sat - CNT_W'(1);
    assign count_ge2 = (count_sat >= CNT_W'(2));

    assign key_greater = ($signed(key_reg) > $signed(rd_data_reg));
    assign span        = right_reg - left_reg;
    assign status.span_gt1 = (span > AW'(1));

    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        if (cmd.init)
        begin
            left_next  = '0;
            right_next = count_ge2 ? count_m1[AW-1:0] : '0;
        end
        else if (cmd.step)
        begin
            if (key_greater)
            begin
                left_next = rd_addr_hold;
            end
            else
            begin
                right_next = rd_addr_hold;
            end
        end
        bound_sum = {1'b0, left_next} + {1'b0, right_next};
        rd_addr   = bound_sum[AW:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= NUM_POINTS_RESET;
        end
        else if (cfg_wr_en)
        begin
            num_points_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && pos_in_range)
        begin
            mem[pos_ext[AW-1:0]] <= value_in;
        end
        if (cmd.init || cmd.step)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg     <= left_next;
        right_reg    <= right_next;
        rd_addr_hold <= rd_addr;
        if (cmd.init)
        begin
            key_reg <= value_in;
        end
        if (cmd.out_load)
        begin
            interval_reg <= left_ext[INTERVAL_W-1:0];
        end
    end

    assign left_ext       = {{INTERVAL_W{1'b0}}, left_reg};
    assign interval_index = interval_reg;

endmodule

`default_nettype wire

@@ design/sorted_table_interval_search_top.sv @@
// Top level of the sorted table interval search block.
// Depends on stis_pkg, stis_req_if, stis_rsp_if, stis_ctrl and stis_dpath.
`timescale 1ns / 1ps
`default_nettype none

// Breakpoints are loaded one per load transaction (req_type 0) into an internal
// single-port-write, registered-read memory and must be ascending; a query
// transaction (req_type 1) returns the index of the left breakpoint of the
// interval holding sample_value, clamped to 0 below the first point and to
// num_points - 2 above the last. A load leaves the block idle and ready for the
// next request. A query runs a bisection loop that compares against one memory
// word per cycle; the next request is taken once the result is in the output
// register. num_points is written through cfg_wr_en / cfg_wr_data, and the user
// must do so only while the block is idle, which the block itself does not
// enforce; it resets to 1024. There is no clearing pass: entries must be loaded
// before a query reaches them.
module sorted_table_interval_search_top
    import stis_pkg::*;
#(
    parameter int MAX_POINTS  = 1024,
    parameter int VALUE_WIDTH = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    stis_req_if.sink                     req,
    stis_rsp_if.source                   rsp,
    input  wire logic                    cfg_wr_en,
    input  wire logic [NUM_POINTS_W-1:0] cfg_wr_data
);

    stis_cmd_t             cmd;
    stis_status_t          status;
    logic                  req_ready;
    logic                  rsp_valid;
    logic [INTERVAL_W-1:0] interval_index;

    stis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req_ready),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp_valid),
        .status    (status),
        .cmd       (cmd)
    );

    stis_dpath #(
        .MAX_POINTS  (MAX_POINTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .entry_index    (req.entry_index),
        .sample_value   (req.sample_value),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .status         (status),
        .interval_index (interval_index)
    );

    assign req.ready          = req_ready;
    assign rsp.valid          = rsp_valid;
    assign rsp.interval_index = interval_index;

`ifndef NO_ASSERTIONS
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp.valid || rsp.ready))
        else $error("result loaded while previous transaction still pending");

    a_result_after_converge: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !status.span_gt1)
        else $error("result loaded before bounds converged");

    a_busy_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init |=> !req.ready)
        else $error("request accepted during search");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init |=> !cmd.out_load || !rsp.valid || rsp.ready)
        else $error("result hand-off violated after query start");
`endif

endmodule

`default_nettype wire

@@ dv/stis_interval_checker.sv @@
// Checker for the sorted table interval search block: watches the request, response and
// num_points write ports, predicts each query's interval index and compares it.
// Depends on stis_pkg, stis_req_if and stis_rsp_if.
`timescale 1ns / 1ps

module stis_interval_checker
    import stis_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    stis_req_if                     req,
    stis_rsp_if                     rsp,
    input  logic                    cfg_wr_en,
    input  logic [NUM_POINTS_W-1:0] cfg_wr_data,
    output int                      fail_count,
    output int                      pending
);

    logic signed [SAMPLE_W-1:0] breakpoints [TABLE_DEPTH];
    logic [NUM_POINTS_W-1:0]    points_in_use = NUM_POINTS_RESET;
    logic [INTERVAL_W-1:0]      expected_intervals [$];
    int                         mismatches = 0;
    int                         outstanding = 0;

    assign fail_count = mismatches;
    assign pending    = outstanding;

    function automatic logic [INTERVAL_W-1:0] locate_interval(
        logic signed [SAMPLE_W-1:0] query
    );
        int unsigned span;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        span = (points_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(points_in_use);
        lo   = 0;
        if (span >= 2)
        begin
            hi = span - 1;
            while (hi - lo > 1)
            begin
                mid = (lo + hi) / 2;
                if (query > breakpoints[mid])
                    lo = mid;
                else
                    hi = mid;
            end
        end
        return lo[INTERVAL_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [INTERVAL_W-1:0] want;
        if (!rst_n)
        begin
            points_in_use = NUM_POINTS_RESET;
            expected_intervals.delete();
        end
        else
        begin
            if (cfg_wr_en)
                points_in_use = cfg_wr_data;
            if (req.valid && req.ready)
            begin
                if (req.req_type == REQ_LOAD)
                begin
                    if (req.entry_index < TABLE_DEPTH)
                        breakpoints[req.entry_index] = req.sample_value;
                end
                else
                begin
                    expected_intervals.push_back(locate_interval(req.sample_value));
                end
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_intervals.size() == 0)
                begin
                    $display("%0t: unexpected transaction: expected none, actual %0d",
                             $time, rsp.interval_index);
                    mismatches++;
                end
                else
                begin
                    want = expected_intervals.pop_front();
                    if (rsp.interval_index !== want)
                    begin
                        $display("%0t: interval_index mismatch: expected %0d, actual %0d",
                                 $time, want, rsp.interval_index);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = expected_intervals.size();
    end

endmodule

@@ dv/sorted_table_interval_search_top_tb.sv @@
// Testbench top for the sorted table interval search block: drives breakpoint loads,
// interval queries and num_points writes, stalls the response side and gives the verdict.
// Depends on stis_pkg, stis_req_if, stis_rsp_if, the block and stis_interval_checker.
`timescale 1ns / 1ps

module sorted_table_interval_search_top_tb;
    import stis_pkg::*;

    localparam int TABLE_DEPTH   = 1024;
    localparam int RANDOM_ITEMS  = 40;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 250;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [NUM_POINTS_W-1:0] cfg_wr_data;
    int                      fail_count;
    int                      pending;

    stis_req_if req_ch ();
    stis_rsp_if rsp_ch ();

    sorted_table_interval_search_top #(
        .MAX_POINTS  (TABLE_DEPTH),
        .VALUE_WIDTH (SAMPLE_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    stis_interval_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    logic signed [SAMPLE_W-1:0] shadow [TABLE_DEPTH];
    bit                         written [TABLE_DEPTH];
    bit                         req_on;
    int                         burst_left;
    int                         gap_cycles;
    int                         loads_sent;
    int                         queries_sent;
    int                         settings_used;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int cyc;
        int mode;
        int mode_left;
        int hold_left;
        int next_hold;
        cyc       = 0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        next_hold = 200;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_left == 0 && cyc >= next_hold && rsp_ch.valid)
            begin
                hold_left = HOLD_CYCLES;
                next_hold = cyc + 1000;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 1) == 0);
                    2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= (cyc % 3 == 0);
                endcase
            end
        end
    end

    task automatic req_stop();
        if (req_on)
        begin
            req_ch.valid <= 1'b0;
            req_on = 1'b0;
        end
    endtask

    task automatic send_item(req_kind_t kind, logic [ENTRY_INDEX_W-1:0] idx,
                             logic signed [SAMPLE_W-1:0] val);
        if (gap_cycles > 0)
        begin
            repeat (gap_cycles) @(posedge clk);
            gap_cycles = 0;
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.entry_index  <= idx;
        req_ch.sample_value <= val;
        req_on = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (kind == REQ_LOAD)
        begin
            shadow[idx]  = val;
            written[idx] = 1'b1;
            loads_sent++;
        end
        else
        begin
            queries_sent++;
        end
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            req_stop();
            gap_cycles = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 30)
                                                     : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // hold until idle, then update num_points
    task automatic write_points(int unsigned n);
        req_stop();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n[NUM_POINTS_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic load_ascending(int unsigned n);
        longint                     acc;
        longint                     step_max;
        logic signed [SAMPLE_W-1:0] v;
        acc      = -longint'(32'h8000_0000) + longint'($urandom_range(0, 32'h3FFF_FFFF));
        step_max = ($urandom_range(0, 3) == 0) ? 3 : 64'd4294967295 / (n + 1);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (acc > 64'sd2147483647)
                acc = 64'sd2147483647;
            v = SAMPLE_W'(acc);
            send_item(REQ_LOAD, ENTRY_INDEX_W'(i), v);
            acc += longint'($urandom_range(0, 32'(step_max)));
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_query(int unsigned span);
        int unsigned                r;
        int unsigned                k;
        logic signed [SAMPLE_W-1:0] v;
        r = $urandom_range(0, 9);
        if (span == 0 || r < 4)
            return $urandom;
        k = $urandom_range(0, span - 1);
        if (!written[k])
            return $urandom;
        v = shadow[k];
        case (r)
            4, 5:    return v;
            6:       return v + 1;
            7:       return v - 1;
            8:       return 32'sh8000_0000;
            default: return 32'sh7FFF_FFFF;
        endcase
    endfunction

    task automatic run_queries(int unsigned n_points, int unsigned n_queries, bit add_noise);
        int unsigned              eff;
        logic [ENTRY_INDEX_W-1:0] idx;
        eff = (n_points > TABLE_DEPTH) ? TABLE_DEPTH : n_points;
        repeat (n_queries)
        begin
            if (add_noise && $urandom_range(0, 9) == 0)
            begin
                if (eff < TABLE_DEPTH && $urandom_range(0, 2) != 0)
                    idx = ENTRY_INDEX_W'($urandom_range(eff, TABLE_DEPTH - 1));
                else
                    idx = ENTRY_INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
                send_item(REQ_LOAD, idx, $urandom);
            end
            send_item(REQ_QUERY, ENTRY_INDEX_W'($urandom), pick_query(eff));
        end
    endtask

    initial
    begin
        int unsigned n;
        int unsigned r;
        bit          fill;
        int          base;
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_LOAD;
        req_ch.entry_index  <= '0;
        req_ch.sample_value <= '0;
        req_on        = 1'b0;
        gap_cycles    = 0;
        burst_left    = $urandom_range(1, 12);
        loads_sent    = 0;
        queries_sent  = 0;
        settings_used = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // below, on, between and above three breakpoints
        write_points(3);
        send_item(REQ_LOAD, 10'd0, 32'sh8000_0001);
        send_item(REQ_LOAD, 10'd1, 32'sh0000_0000);
        send_item(REQ_LOAD, 10'd2, 32'sh7FFF_FFFE);
        send_item(REQ_LOAD, 10'h3FF, 32'sh5555_5555);
        send_item(REQ_LOAD, 10'h3FF, 32'shAAAA_AAAA);
        send_item(REQ_QUERY, 10'h3FF, 32'sh8000_0000);
        send_item(REQ_QUERY, 10'h000, 32'sh8000_0001);
        send_item(REQ_QUERY, 10'h155, 32'shFFFF_FFFF);
        send_item(REQ_QUERY, 10'h2AA, 32'sh0000_0000);
        send_item(REQ_QUERY, 10'h000, 32'sh0000_0001);
        send_item(REQ_QUERY, 10'h000, 32'sh7FFF_FFFE);
        send_item(REQ_QUERY, 10'h000, 32'sh7FFF_FFFF);
        write_points(1);
        send_item(REQ_QUERY, 10'h000, 32'sh0001_2340);
        write_points(0);
        send_item(REQ_QUERY, 10'h000, $urandom);
        write_points(2);
        send_item(REQ_QUERY, 10'h000, 32'sh8000_0000);
        send_item(REQ_QUERY, 10'h000, 32'sh7FFF_FFFF);

        // full table, then counts past the table size
        write_points(TABLE_DEPTH);
        load_ascending(TABLE_DEPTH);
        run_queries(TABLE_DEPTH, 12, 1'b0);
        write_points(2047);
        run_queries(2047, 6, 1'b0);
        write_points(1025);
        run_queries(1025, 6, 1'b1);

        base = loads_sent + queries_sent;
        while (loads_sent + queries_sent - base < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                n    = $urandom_range(0, 1);
                fill = 1'b0;
            end
            else if (r < 60)
            begin
                n    = $urandom_range(2, 33);
                fill = 1'b1;
            end
            else if (r < 85)
            begin
                n    = $urandom_range(34, 200);
                fill = 1'b1;
            end
            else
            begin
                n    = $urandom_range(201, 2047);
                fill = 1'b0;
            end
            write_points(n);
            if (fill)
                load_ascending(n);
            run_queries(n, $urandom_range(8, 40), 1'b1);
        end

        req_stop();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d breakpoint loads and %0d interval queries over %0d num_points",
                 loads_sent, queries_sent, settings_used);
        $display("settings (0, 1, 2, full table, past table size), with %0d mismatches seen",
                 fail_count);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
